/* rtl/tbfe_pkg.sv */
package tbfe_pkg;

   // Fixed field widths of the register file and the ports
   localparam int LEN_W      = 13;   // trace, window and baseline lengths
   localparam int POS_W      = 12;   // window start and baseline gap
   localparam int CLIP_W     = 17;   // clip limits
   localparam int SAMPLE_W   = 16;   // sample port
   localparam int BASE_OUT_W = 24;
   localparam int SUM_OUT_W  = 37;
   localparam int PEAK_OUT_W = 25;
   localparam int GOOD_OUT_W = 13;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 17;

   // Register indexes of the configuration port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TRACE_LENGTH  = 3'd0,
      CSR_WINDOW_START  = 3'd1,
      CSR_WINDOW_LENGTH = 3'd2,
      CSR_BASE_LENGTH   = 3'd3,
      CSR_BASE_GAP      = 3'd4,
      CSR_CLIP_HIGH     = 3'd5,
      CSR_CLIP_LOW      = 3'd6
   } tbfe_csr_type;

   // Trace-end sequencer
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SETUP  = 7'b0000010,
      S_DIV    = 7'b0000100,
      S_MUL    = 7'b0001000,
      S_SUB    = 7'b0010000,
      S_PEAK   = 7'b0100000,
      S_TROUGH = 7'b1000000
   } tbfe_state_type;

   // Sequencer to accumulator control
   typedef struct packed {
      logic take;    // sample transaction accepted
      logic clear;   // start a new trace
   } tbfe_ctl_type;

   // Accumulator status toward the sequencer
   typedef struct packed {
      logic last;       // current sample ends the trace
      logic win_over;   // window runs past the trace end
      logic win_seen;   // at least one window sample seen
   } tbfe_stat_type;

endpackage

/* rtl/tbfe_alu.sv */
module tbfe_alu import tbfe_pkg::*; #(
   parameter int WIDTH = 38
) (
   input  logic                    sub,
   input  logic        [WIDTH-1:0] opa,
   input  logic        [WIDTH-1:0] opb,
   output logic signed [WIDTH-1:0] res,
   output logic                    neg
);

   // Shared adder/subtractor: divide steps, multiply steps and final offsets
   assign res = sub ? $signed(opa - opb) : $signed(opa + opb);
   assign neg = res[WIDTH-1];

endmodule

/* rtl/tbfe_accum.sv */
module tbfe_accum import tbfe_pkg::*; #(
   parameter  int MAX_TRACE   = 4096,
   parameter  int SAMPLE_BITS = 16,
   localparam int CNT_W       = $clog2(MAX_TRACE) + 1,
   localparam int ACC_W       = SAMPLE_BITS + CNT_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tbfe_ctl_type             ctl,
   input  logic [SAMPLE_BITS-1:0]   sample,
   input  logic [LEN_W-1:0]         trace_length,
   input  logic [POS_W-1:0]         window_start,
   input  logic [LEN_W-1:0]         window_length,
   input  logic [LEN_W-1:0]         base_length,
   input  logic [POS_W-1:0]         base_gap,
   input  logic [CLIP_W-1:0]        clip_high,
   input  logic signed [CLIP_W-1:0] clip_low,
   output tbfe_stat_type            stat,
   output logic [ACC_W-1:0]         base_accum,
   output logic [CNT_W-1:0]         base_count,
   output logic [ACC_W-1:0]         win_accum,
   output logic [SAMPLE_BITS-1:0]   win_max,
   output logic [SAMPLE_BITS-1:0]   win_min,
   output logic [CNT_W-1:0]         good_count
);

   localparam int IDX_W  = $clog2(MAX_TRACE);
   localparam int CMP_W  = ((IDX_W > 14) ? IDX_W : 14) + 2;
   localparam int CLIP_X = ((SAMPLE_BITS > CLIP_W) ? SAMPLE_BITS : CLIP_W) + 1;

   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [ACC_W-1:0]       bacc_ff, bacc_in, wacc_ff, wacc_in;
   logic [CNT_W-1:0]       bcnt_ff, bcnt_in, good_ff, good_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in, min_ff, min_in;
   logic                   seen_ff, seen_in;

   logic signed [CMP_W-1:0]  idx_s, len_s, tl_s, ws_s, we_s, be_s, bs_s;
   logic signed [CLIP_X-1:0] smp_c, hi_c, lo_c;
   logic                     in_base, in_win, clip_ok;

   // Window bounds and effective trace length
   always_comb begin
      tl_s  = CMP_W'(trace_length);
      if (tl_s == '0) begin
         len_s = CMP_W'(1);
      end else if (tl_s > CMP_W'(MAX_TRACE)) begin
         len_s = CMP_W'(MAX_TRACE);
      end else begin
         len_s = tl_s;
      end
      idx_s = CMP_W'(idx_ff);
      ws_s  = CMP_W'(window_start);
      we_s  = ws_s + CMP_W'(window_length);
      be_s  = ws_s - CMP_W'(base_gap);
      bs_s  = be_s - CMP_W'(base_length);
   end

   assign in_base = (idx_s >= bs_s) && (idx_s < be_s);
   assign in_win  = (idx_s >= ws_s) && (idx_s < we_s);

   // Clip test, signed since the low limit may be negative
   assign smp_c   = CLIP_X'(sample);
   assign hi_c    = CLIP_X'(clip_high);
   assign lo_c    = CLIP_X'(clip_low);
   assign clip_ok = (smp_c < hi_c) && (smp_c > lo_c);

   assign stat.last     = (idx_s + CMP_W'(1)) >= len_s;
   assign stat.win_over = we_s > len_s;
   assign stat.win_seen = seen_ff;

   // Per-sample update
   always_comb begin
      idx_in  = idx_ff;
      bacc_in = bacc_ff;
      bcnt_in = bcnt_ff;
      wacc_in = wacc_ff;
      max_in  = max_ff;
      min_in  = min_ff;
      good_in = good_ff;
      seen_in = seen_ff;
      if (ctl.clear) begin
         idx_in  = '0;
         bacc_in = '0;
         bcnt_in = '0;
         wacc_in = '0;
         max_in  = '0;
         min_in  = '1;
         good_in = '0;
         seen_in = 1'b0;
      end else if (ctl.take) begin
         if (!stat.last) begin
            idx_in = idx_ff + IDX_W'(1);
         end
         if (in_base) begin
            bacc_in = bacc_ff + ACC_W'(sample);
            bcnt_in = bcnt_ff + CNT_W'(1);
         end
         if (in_win) begin
            wacc_in = wacc_ff + ACC_W'(sample);
            seen_in = 1'b1;
            if (sample > max_ff) begin
               max_in = sample;
            end
            if (sample < min_ff) begin
               min_in = sample;
            end
            if (clip_ok) begin
               good_in = good_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         bacc_ff <= '0;
         bcnt_ff <= '0;
         wacc_ff <= '0;
         max_ff  <= '0;
         min_ff  <= '1;
         good_ff <= '0;
         seen_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         bacc_ff <= bacc_in;
         bcnt_ff <= bcnt_in;
         wacc_ff <= wacc_in;
         max_ff  <= max_in;
         min_ff  <= min_in;
         good_ff <= good_in;
         seen_ff <= seen_in;
      end
   end

   assign base_accum = bacc_ff;
   assign base_count = bcnt_ff;
   assign win_accum  = wacc_ff;
   assign win_max    = max_ff;
   assign win_min    = min_ff;
   assign good_count = good_ff;

endmodule

/* rtl/trace_baseline_feature_extractor.sv */
// Trace baseline feature extractor. Samples of one trace arrive one per req
// transaction and are counted against trace_length; the baseline is the mean
// of base_length samples ending base_gap samples before the analysis window,
// and over the window the block sums the samples and tracks maximum, minimum
// and the count strictly inside the clip limits. Every sample but the last
// of a trace is taken as soon as it is offered. The last sample starts the
// trace-end sequence on one shared adder/subtractor, during which req_stall
// is high: a setup step, a restoring divide of one quotient bit per cycle
// (skipped when the baseline window is empty), a shift-add multiply by
// window_length, and three subtract steps. The result then goes into the
// rsp output register, so the next trace can start while the result waits
// to be taken. Values carry FRAC_BITS fraction bits; the baseline division
// truncates. The user must write configuration only while the block is
// idle; the block itself does not enforce this.
module trace_baseline_feature_extractor import tbfe_pkg::*; #(
   parameter int MAX_TRACE   = 4096,
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_write_en,
   input  logic [CSR_ADDR_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   // samples
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [SAMPLE_W-1:0]          req_sample,
   // results
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [BASE_OUT_W-1:0]        rsp_baseline_value,
   output logic signed [SUM_OUT_W-1:0]  rsp_window_sum,
   output logic signed [PEAK_OUT_W-1:0] rsp_peak_value,
   output logic signed [PEAK_OUT_W-1:0] rsp_trough_value,
   output logic [GOOD_OUT_W-1:0]        rsp_good_count,
   output logic                         rsp_window_error,
   output logic                         rsp_baseline_error
);

   localparam int CNT_W  = $clog2(MAX_TRACE) + 1;
   localparam int ACC_W  = SAMPLE_BITS + CNT_W;
   localparam int BASE_W = SAMPLE_BITS + FRAC_BITS;
   localparam int DIV_W  = ACC_W + FRAC_BITS;
   localparam int REM_W  = CNT_W + 1;
   localparam int ALU_W  = ((DIV_W > BASE_W + LEN_W) ? DIV_W : BASE_W + LEN_W) + 1;
   localparam int STEP_W = $clog2(DIV_W + 1);

   // Configuration registers
   logic [LEN_W-1:0]         trace_length_ff, window_length_ff, base_length_ff;
   logic [POS_W-1:0]         window_start_ff, base_gap_ff;
   logic [CLIP_W-1:0]        clip_high_ff;
   logic signed [CLIP_W-1:0] clip_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_length_ff  <= LEN_W'(4096);
         window_start_ff  <= '0;
         window_length_ff <= LEN_W'(1);
         base_length_ff   <= LEN_W'(1);
         base_gap_ff      <= '0;
         clip_high_ff     <= CLIP_W'(65536);
         clip_low_ff      <= '1;
      end else if (csr_write_en) begin
         unique case (tbfe_csr_type'(csr_index))
            CSR_TRACE_LENGTH:  trace_length_ff  <= csr_wdata[LEN_W-1:0];
            CSR_WINDOW_START:  window_start_ff  <= csr_wdata[POS_W-1:0];
            CSR_WINDOW_LENGTH: window_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_BASE_LENGTH:   base_length_ff   <= csr_wdata[LEN_W-1:0];
            CSR_BASE_GAP:      base_gap_ff      <= csr_wdata[POS_W-1:0];
            CSR_CLIP_HIGH:     clip_high_ff     <= csr_wdata[CLIP_W-1:0];
            CSR_CLIP_LOW:      clip_low_ff      <= $signed(csr_wdata[CLIP_W-1:0]);
            default: ;
         endcase
      end
   end

   // Sequencer state and datapath registers
   tbfe_state_type     state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   dq_ff, dq_in;
   logic [ALU_W-1:0]   prod_ff, prod_in;
   logic [LEN_W-1:0]   mlt_ff, mlt_in;
   logic signed [PEAK_OUT_W-1:0] peak_ff, peak_in, trough_ff, trough_in;
   logic               load_out;

   tbfe_ctl_type  ctl;
   tbfe_stat_type stat;

   logic [ACC_W-1:0]       base_accum, win_accum;
   logic [CNT_W-1:0]       base_count, good_count;
   logic [SAMPLE_BITS-1:0] win_max, win_min;
   logic                   take;

   assign req_stall = (state_ff != S_IDLE);
   assign take      = req_valid && !req_stall;
   assign ctl.take  = take;
   assign ctl.clear = load_out;

   tbfe_accum #(
      .MAX_TRACE   (MAX_TRACE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_accum (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sample        (SAMPLE_BITS'(req_sample)),
      .trace_length  (trace_length_ff),
      .window_start  (window_start_ff),
      .window_length (window_length_ff),
      .base_length   (base_length_ff),
      .base_gap      (base_gap_ff),
      .clip_high     (clip_high_ff),
      .clip_low      (clip_low_ff),
      .stat          (stat),
      .base_accum    (base_accum),
      .base_count    (base_count),
      .win_accum     (win_accum),
      .win_max       (win_max),
      .win_min       (win_min),
      .good_count    (good_count)
   );

   // Shared add/subtract unit and its operand select
   logic                     alu_sub, alu_neg;
   logic [ALU_W-1:0]         alu_a, alu_b;
   logic signed [ALU_W-1:0]  alu_res;
   logic [REM_W-1:0]         rem_shift;
   logic [BASE_W-1:0]        base;

   assign rem_shift = {rem_ff[REM_W-2:0], dq_ff[DIV_W-1]};
   assign base      = BASE_W'(dq_ff);

   always_comb begin
      alu_sub = 1'b0;
      alu_a   = '0;
      alu_b   = '0;
      unique case (state_ff)
         S_DIV: begin
            alu_sub = 1'b1;
            alu_a   = ALU_W'(rem_shift);
            alu_b   = ALU_W'(base_count);
         end
         S_MUL: begin
            alu_a = prod_ff << 1;
            alu_b = mlt_ff[LEN_W-1] ? ALU_W'(base) : '0;
         end
         S_SUB: begin
            alu_sub = 1'b1;
            alu_a   = ALU_W'(win_accum) << FRAC_BITS;
            alu_b   = prod_ff;
         end
         S_PEAK: begin
            alu_sub = 1'b1;
            alu_a   = ALU_W'(win_max) << FRAC_BITS;
            alu_b   = ALU_W'(base);
         end
         S_TROUGH: begin
            alu_sub = 1'b1;
            alu_a   = ALU_W'(win_min) << FRAC_BITS;
            alu_b   = ALU_W'(base);
         end
         default: ;
      endcase
   end

   tbfe_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .sub (alu_sub),
      .opa (alu_a),
      .opb (alu_b),
      .res (alu_res),
      .neg (alu_neg)
   );

   // Trace-end sequencer: divide, multiply, offsets, hand-off
   logic out_free, load_ready;

   assign out_free   = !rsp_valid || !rsp_stall;
   assign load_ready = (state_ff == S_TROUGH) && (step_ff == '0);

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      dq_in     = dq_ff;
      prod_in   = prod_ff;
      mlt_in    = mlt_ff;
      peak_in   = peak_ff;
      trough_in = trough_ff;
      load_out  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (take && stat.last) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            rem_in = '0;
            if (base_count == '0) begin
               dq_in    = '0;
               step_in  = STEP_W'(LEN_W);
               prod_in  = '0;
               mlt_in   = window_length_ff;
               state_in = S_MUL;
            end else begin
               dq_in    = DIV_W'(base_accum) << FRAC_BITS;
               step_in  = STEP_W'(DIV_W);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // one restoring quotient bit per cycle
            if (!alu_neg) begin
               rem_in = REM_W'(alu_res);
            end else begin
               rem_in = rem_shift;
            end
            dq_in   = {dq_ff[DIV_W-2:0], !alu_neg};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               step_in  = STEP_W'(LEN_W);
               prod_in  = '0;
               mlt_in   = window_length_ff;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // shift-add, multiplier bits from the top
            prod_in = ALU_W'(alu_res);
            mlt_in  = mlt_ff << 1;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = S_SUB;
            end
         end
         S_SUB: begin
            prod_in  = ALU_W'(alu_res);
            state_in = S_PEAK;
         end
         S_PEAK: begin
            peak_in  = PEAK_OUT_W'(alu_res);
            state_in = S_TROUGH;
         end
         S_TROUGH: begin
            // compute the trough on entry, then wait for the output slot
            if (step_ff != '0) begin
               trough_in = PEAK_OUT_W'(alu_res);
               step_in   = '0;
            end else if (out_free) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // step counter is zero after the multiply; set it to one to mark the trough as pending
      if (state_ff == S_PEAK) begin
         step_in = STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      dq_ff     <= dq_in;
      prod_ff   <= prod_in;
      mlt_ff    <= mlt_in;
      peak_ff   <= peak_in;
      trough_ff <= trough_in;
   end

   // Output register
   logic rsp_valid_ff, rsp_valid_in;
   logic werr, berr, zero_ext;

   assign werr     = stat.win_over;
   assign berr     = (base_count == '0);
   assign zero_ext = werr || !stat.win_seen;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_baseline_value <= BASE_OUT_W'(base);
         rsp_window_sum     <= werr ? '0 : SUM_OUT_W'($signed(prod_ff));
         rsp_peak_value     <= zero_ext ? '0 : peak_ff;
         rsp_trough_value   <= zero_ext ? '0 : trough_ff;
         rsp_good_count     <= werr ? '0 : GOOD_OUT_W'(good_count);
         rsp_window_error   <= werr;
         rsp_baseline_error <= berr;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Checks
   a_last_starts_seq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && stat.last) |=> (state_ff == S_SETUP))
      else $error("last sample did not start the trace-end sequence");

   a_load_hands_off: assert property (@(posedge clock) disable iff (reset)
      (load_ready && out_free) |=> (rsp_valid && state_ff == S_IDLE))
      else $error("finished result not moved to the output register");

   a_berr_zero_base: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_baseline_error) |-> (rsp_baseline_value == '0))
      else $error("empty baseline window with nonzero baseline");

   a_werr_zero_sums: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_window_error) |->
         (rsp_window_sum == '0 && rsp_good_count == '0 &&
          rsp_peak_value == '0 && rsp_trough_value == '0))
      else $error("window error with nonzero window results");

endmodule

/* dv/tb_trace_baseline_feature_extractor.sv */
module tb_trace_baseline_feature_extractor;
   import tbfe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_TRACE      = 4096;
   localparam int FRACTION_BITS  = 8;
   localparam int RANDOM_PHASES  = 16;
   localparam int PHASE_ITEMS    = 110;
   localparam int PRESSURE_PHASE = 4;
   localparam int PAUSE_PHASE    = 5;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 100;
   localparam int STALL_LIMIT    = 5000;
   localparam int REPORT_LIMIT   = 10;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_t;

   // one trace-end result, field for field as the rsp channel carries it
   typedef struct packed {
      logic [BASE_OUT_W-1:0]        baseline;
      logic signed [SUM_OUT_W-1:0]  sum;
      logic signed [PEAK_OUT_W-1:0] peak;
      logic signed [PEAK_OUT_W-1:0] trough;
      logic [GOOD_OUT_W-1:0]        good;
      logic                         window_error;
      logic                         baseline_error;
   } trace_features_t;

   typedef struct {
      int unsigned trace_length;
      int unsigned window_start;
      int unsigned window_length;
      int unsigned base_length;
      int unsigned base_gap;
      int unsigned clip_high;
      int unsigned clip_low;
   } reg_setting_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [BASE_OUT_W-1:0] rsp_baseline_value;
   logic signed [SUM_OUT_W-1:0] rsp_window_sum;
   logic signed [PEAK_OUT_W-1:0] rsp_peak_value;
   logic signed [PEAK_OUT_W-1:0] rsp_trough_value;
   logic [GOOD_OUT_W-1:0] rsp_good_count;
   logic rsp_window_error;
   logic rsp_baseline_error;

   logic sample_taken;
   logic result_taken;

   logic [SAMPLE_W-1:0] sample_backlog[$];
   trace_features_t     expected_features[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int hold_served;
   int hold_left;
   int idle_cycles;
   int feature_errors = 0;

   // predictor copy of the register file
   logic [LEN_W-1:0]  cfg_trace_length;
   logic [POS_W-1:0]  cfg_window_start;
   logic [LEN_W-1:0]  cfg_window_length;
   logic [LEN_W-1:0]  cfg_base_length;
   logic [POS_W-1:0]  cfg_base_gap;
   logic [CLIP_W-1:0] cfg_clip_high;
   logic [CLIP_W-1:0] cfg_clip_low;

   // predictor copy of the per-trace accumulators
   int                trc_index;
   longint            trc_base_sum;
   int                trc_base_cnt;
   longint            trc_win_sum;
   logic [SAMPLE_W-1:0] trc_win_max;
   logic [SAMPLE_W-1:0] trc_win_min;
   int                trc_good;
   int                trc_win_seen;

   trace_baseline_feature_extractor u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_baseline_value (rsp_baseline_value),
      .rsp_window_sum     (rsp_window_sum),
      .rsp_peak_value     (rsp_peak_value),
      .rsp_trough_value   (rsp_trough_value),
      .rsp_good_count     (rsp_good_count),
      .rsp_window_error   (rsp_window_error),
      .rsp_baseline_error (rsp_baseline_error)
   );

   assign sample_taken = req_valid && !req_stall;
   assign result_taken = rsp_valid && !rsp_stall;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void clear_trace_state();
      trc_index    = 0;
      trc_base_sum = 0;
      trc_base_cnt = 0;
      trc_win_sum  = 0;
      trc_win_max  = '0;
      trc_win_min  = '1;
      trc_good     = 0;
      trc_win_seen = 0;
   endfunction

   // fold one sample into the trace; on the last sample queue the features
   task automatic accumulate_sample(input logic [SAMPLE_W-1:0] s);
      int span, wstart, wend, bend, bstart;
      longint lo, base, sum, peak, trough;
      trace_features_t res;
      span = (cfg_trace_length == 0) ? 1 :
             (cfg_trace_length > MAX_TRACE) ? MAX_TRACE : int'(cfg_trace_length);
      wstart = int'(cfg_window_start);
      wend   = wstart + int'(cfg_window_length);
      bend   = wstart - int'(cfg_base_gap);
      bstart = bend - int'(cfg_base_length);
      lo     = longint'($signed(cfg_clip_low));

      if (trc_index >= bstart && trc_index < bend) begin
         trc_base_sum += s;
         trc_base_cnt++;
      end
      if (trc_index >= wstart && trc_index < wend) begin
         trc_win_sum += s;
         if (s > trc_win_max) trc_win_max = s;
         if (s < trc_win_min) trc_win_min = s;
         if (s < cfg_clip_high && longint'(s) > lo) trc_good++;
         trc_win_seen++;
      end

      if (trc_index + 1 < span) begin
         trc_index++;
      end else begin
         base   = 0;
         sum    = 0;
         peak   = 0;
         trough = 0;
         res.baseline_error = (trc_base_cnt == 0);
         res.window_error   = (wend > span);
         res.good           = '0;
         if (!res.baseline_error) base = (trc_base_sum <<< FRACTION_BITS) / trc_base_cnt;
         // out-of-range window zeroes everything but the baseline
         if (!res.window_error) begin
            sum = (trc_win_sum <<< FRACTION_BITS) - base * longint'(cfg_window_length);
            if (trc_win_seen != 0) begin
               peak   = (longint'(trc_win_max) <<< FRACTION_BITS) - base;
               trough = (longint'(trc_win_min) <<< FRACTION_BITS) - base;
            end
            res.good = trc_good[GOOD_OUT_W-1:0];
         end
         res.baseline = base[BASE_OUT_W-1:0];
         res.sum      = sum[SUM_OUT_W-1:0];
         res.peak     = peak[PEAK_OUT_W-1:0];
         res.trough   = trough[PEAK_OUT_W-1:0];
         expected_features.push_back(res);
         clear_trace_state();
      end
   endtask

   // sample driver: drives the backlog onto req, predicts on each accepted transaction
   always @(posedge clock) begin : sample_driver
      logic offer;
      if (reset) begin
         req_valid         <= 1'b0;
         req_sample        <= '0;
         cfg_trace_length  = LEN_W'(4096);
         cfg_window_start  = '0;
         cfg_window_length = LEN_W'(1);
         cfg_base_length   = LEN_W'(1);
         cfg_base_gap      = '0;
         cfg_clip_high     = CLIP_W'(65536);
         cfg_clip_low      = '1;
         clear_trace_state();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_TRACE_LENGTH:  cfg_trace_length  = csr_wdata[LEN_W-1:0];
               CSR_WINDOW_START:  cfg_window_start  = csr_wdata[POS_W-1:0];
               CSR_WINDOW_LENGTH: cfg_window_length = csr_wdata[LEN_W-1:0];
               CSR_BASE_LENGTH:   cfg_base_length   = csr_wdata[LEN_W-1:0];
               CSR_BASE_GAP:      cfg_base_gap      = csr_wdata[POS_W-1:0];
               CSR_CLIP_HIGH:     cfg_clip_high     = csr_wdata[CLIP_W-1:0];
               CSR_CLIP_LOW:      cfg_clip_low      = csr_wdata[CLIP_W-1:0];
               default: ;
            endcase
         end
         offer = req_valid;
         if (sample_taken) begin
            accumulate_sample(req_sample);
            void'(sample_backlog.pop_front());
            offer = 1'b0;
         end
         if (!offer && sample_backlog.size() != 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            offer = 1'b1;
            req_sample <= sample_backlog[0];
         end
         req_valid <= offer;
      end
   end

   // result back-pressure: random stalls plus requested long hold-offs
   always @(posedge clock) begin : result_stall
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_left   <= 0;
         hold_served <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_stall   <= 1'b1;
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   task automatic log_feature_error(input string what, input trace_features_t want,
                                    input trace_features_t got);
      feature_errors++;
      if (feature_errors <= REPORT_LIMIT) begin
         $display("%0t %s", $realtime, what);
         $display("   expected base=%0d sum=%0d peak=%0d trough=%0d good=%0d werr=%0b berr=%0b",
                  want.baseline, want.sum, want.peak, want.trough, want.good,
                  want.window_error, want.baseline_error);
         $display("   actual   base=%0d sum=%0d peak=%0d trough=%0d good=%0d werr=%0b berr=%0b",
                  got.baseline, got.sum, got.peak, got.trough, got.good,
                  got.window_error, got.baseline_error);
      end
   endtask

   // result monitor: compare each transaction with the oldest prediction
   always @(posedge clock) begin : result_monitor
      trace_features_t got, want;
      if (!reset && result_taken) begin
         got.baseline       = rsp_baseline_value;
         got.sum            = rsp_window_sum;
         got.peak           = rsp_peak_value;
         got.trough         = rsp_trough_value;
         got.good           = rsp_good_count;
         got.window_error   = rsp_window_error;
         got.baseline_error = rsp_baseline_error;
         if (expected_features.size() == 0) begin
            log_feature_error("result with no trace pending", '0, got);
         end else begin
            want = expected_features.pop_front();
            if (got.baseline !== want.baseline || got.sum !== want.sum ||
                got.peak !== want.peak || got.trough !== want.trough ||
                got.good !== want.good || got.window_error !== want.window_error ||
                got.baseline_error !== want.baseline_error)
               log_feature_error("trace features mismatch", want, got);
         end
      end
   end

   // no progress on any port for too long means a hang
   always @(posedge clock) begin : stall_watchdog
      if (reset || sample_taken || result_taken || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic reg_setting_t make_setting(input int unsigned tl, ws, wl, bl, bg,
                                                 ch, cl);
      reg_setting_t s;
      s.trace_length  = tl;
      s.window_start  = ws;
      s.window_length = wl;
      s.base_length   = bl;
      s.base_gap      = bg;
      s.clip_high     = ch;
      s.clip_low      = cl;
      return s;
   endfunction

   // mostly short traces; in half the settings a register at its extreme
   function automatic reg_setting_t rand_setting();
      reg_setting_t s;
      int unsigned span;
      span = $urandom_range(1, 40);
      s.trace_length  = (span == 1 && $urandom_range(0, 1) == 1) ? 0 : span;
      s.window_start  = $urandom_range(0, span);
      s.window_length = $urandom_range(0, span - s.window_start + 1);
      s.base_length   = $urandom_range(0, 10);
      s.base_gap      = $urandom_range(0, 4);
      case ($urandom_range(0, 7))
         0: s.window_start  = 4095;
         1: s.window_length = 8191;
         2: s.base_length   = 8191;
         3: s.base_gap      = 4095;
         default: ;
      endcase
      case ($urandom_range(0, 3))
         0: s.clip_high = 65536;
         1: s.clip_high = $urandom_range(0, 131071);
         2: s.clip_high = $urandom_range(0, 65535);
         default: s.clip_high = 0;
      endcase
      case ($urandom_range(0, 3))
         0: s.clip_low = 17'h1FFFF;
         1: s.clip_low = 17'h10000;
         2: s.clip_low = $urandom_range(0, 131071);
         default: s.clip_low = $urandom_range(0, 65535);
      endcase
      return s;
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic write_reg(input tbfe_csr_type which, input int unsigned value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= which;
      csr_wdata    <= value[CSR_DATA_W-1:0];
   endtask

   task automatic program_regs(input reg_setting_t s);
      write_reg(CSR_TRACE_LENGTH, s.trace_length);
      write_reg(CSR_WINDOW_START, s.window_start);
      write_reg(CSR_WINDOW_LENGTH, s.window_length);
      write_reg(CSR_BASE_LENGTH, s.base_length);
      write_reg(CSR_BASE_GAP, s.base_gap);
      write_reg(CSR_CLIP_HIGH, s.clip_high);
      write_reg(CSR_CLIP_LOW, s.clip_low);
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_idling(input idle_mode_t mode);
      case (mode)
         IDLE_SENDER:   begin send_idle_pct = 75; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 75; end
         IDLE_BOTH:     begin send_idle_pct = 23; recv_stall_pct = 23; end
         default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   // wait until every sample is in and every trace result is out
   task automatic wait_quiet(input int drain);
      do @(negedge clock);
      while (sample_backlog.size() != 0 || req_valid || expected_features.size() != 0);
      repeat (drain) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic push_traces(input reg_setting_t s, input int target);
      int span, pushed;
      span = (s.trace_length == 0) ? 1 :
             (s.trace_length > MAX_TRACE) ? MAX_TRACE : int'(s.trace_length);
      pushed = 0;
      while (pushed < target) begin
         repeat (span) sample_backlog.push_back(rand_sample());
         pushed += span;
      end
   endtask

   initial begin : stimulus
      reg_setting_t s;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);

      // zero trace length acts as one; empty baseline; full-scale and zero samples
      program_regs(make_setting(0, 0, 1, 1, 0, 65536, 17'h1FFFF));
      sample_backlog.push_back(16'hFFFF);
      sample_backlog.push_back(16'h0000);
      wait_quiet(DRAIN_CYCLES);

      // empty analysis window, clip limits at their lowest
      program_regs(make_setting(4, 2, 0, 2, 0, 0, 17'h10000));
      sample_backlog.push_back(16'd100);
      sample_backlog.push_back(16'd300);
      sample_backlog.push_back(16'd7);
      sample_backlog.push_back(16'd9);
      wait_quiet(DRAIN_CYCLES);

      // window runs past the trace end
      program_regs(make_setting(4, 3, 2, 3, 0, 100, 50));
      sample_backlog.push_back(16'd50);
      sample_backlog.push_back(16'd51);
      sample_backlog.push_back(16'd99);
      sample_backlog.push_back(16'd100);
      wait_quiet(DRAIN_CYCLES);

      // samples on and between the clip limits
      program_regs(make_setting(6, 1, 4, 1, 0, 100, 50));
      sample_backlog.push_back(16'd50);
      sample_backlog.push_back(16'd51);
      sample_backlog.push_back(16'd99);
      sample_backlog.push_back(16'd100);
      sample_backlog.push_back(16'd101);
      sample_backlog.push_back(16'd20);
      wait_quiet(DRAIN_CYCLES);

      // trace length cut below the current index mid-trace
      s = make_setting(8, 0, 3, 2, 0, 65536, 17'h1FFFF);
      program_regs(s);
      repeat (5) sample_backlog.push_back(rand_sample());
      wait_quiet(DRAIN_CYCLES);
      s.trace_length = 3;
      program_regs(s);
      sample_backlog.push_back(rand_sample());
      wait_quiet(DRAIN_CYCLES);

      // one full-size trace: length clamped, full-scale baseline, zero in window
      program_regs(make_setting(8191, 4095, 1, 8191, 0, 17'h1FFFF, 65535));
      repeat (MAX_TRACE - 1) sample_backlog.push_back(16'hFFFF);
      sample_backlog.push_back(16'h0000);
      wait_quiet(DRAIN_CYCLES);

      // random settings and traces under each idling pattern
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         s = rand_setting();
         if (phase == PRESSURE_PHASE) s.trace_length = $urandom_range(2, 6);
         program_regs(s);
         set_idling(idle_mode_t'(phase % 4));
         if (phase == PRESSURE_PHASE) hold_requests++;
         if (phase == PAUSE_PHASE) begin
            push_traces(s, PHASE_ITEMS / 2);
            wait_quiet(0);
            push_traces(s, PHASE_ITEMS / 2);
         end else begin
            push_traces(s, PHASE_ITEMS);
         end
         wait_quiet(DRAIN_CYCLES);
      end

      if (feature_errors == 0 && expected_features.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
